// ===== hw/rtl/dtti_pkg.sv =====
// dtti_pkg: shared types, codes and constant tables for the decimal text to integer block.
// Used by dtti_regs, dtti_parse, dtti_fmt and decimal_text_to_integer. No dependencies.
`timescale 1ns / 1ps

package dtti_pkg;

	localparam int MAX_FIELD_CHARS = 1024;
	localparam int POS_W = $clog2(MAX_FIELD_CHARS + 1);
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 64;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FIELD_CHARS);

	// register indexes
	localparam logic REG_VALUE_WIDTH = 1'b0;
	localparam logic REG_SIGNED_MODE = 1'b1;

	// parser phases
	localparam logic [2:0] PH_WS       = 3'd0;
	localparam logic [2:0] PH_WS_SIGN  = 3'd1;
	localparam logic [2:0] PH_DIGITS   = 3'd2;
	localparam logic [2:0] PH_ENDED    = 3'd3;
	localparam logic [2:0] PH_OVERFLOW = 3'd4;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PARSE_ERR = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// limit table, index {signed, signed & negative, width}; entries 4..7 unreachable
	localparam logic [63:0] LIM_TAB [16] = '{
		64'hFF, 64'hFFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFF, 64'hFFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'h7F, 64'h7FFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
		64'h80, 64'h8000, 64'h8000_0000, 64'h8000_0000_0000_0000
	};

	localparam logic [63:0] PRE_TAB [16] = '{
		LIM_TAB[0] / 64'd10,  LIM_TAB[1] / 64'd10,  LIM_TAB[2] / 64'd10,  LIM_TAB[3] / 64'd10,
		LIM_TAB[4] / 64'd10,  LIM_TAB[5] / 64'd10,  LIM_TAB[6] / 64'd10,  LIM_TAB[7] / 64'd10,
		LIM_TAB[8] / 64'd10,  LIM_TAB[9] / 64'd10,  LIM_TAB[10] / 64'd10, LIM_TAB[11] / 64'd10,
		LIM_TAB[12] / 64'd10, LIM_TAB[13] / 64'd10, LIM_TAB[14] / 64'd10, LIM_TAB[15] / 64'd10
	};

	localparam logic [3:0] REM_TAB [16] = '{
		4'(LIM_TAB[0] % 64'd10),  4'(LIM_TAB[1] % 64'd10),
		4'(LIM_TAB[2] % 64'd10),  4'(LIM_TAB[3] % 64'd10),
		4'(LIM_TAB[4] % 64'd10),  4'(LIM_TAB[5] % 64'd10),
		4'(LIM_TAB[6] % 64'd10),  4'(LIM_TAB[7] % 64'd10),
		4'(LIM_TAB[8] % 64'd10),  4'(LIM_TAB[9] % 64'd10),
		4'(LIM_TAB[10] % 64'd10), 4'(LIM_TAB[11] % 64'd10),
		4'(LIM_TAB[12] % 64'd10), 4'(LIM_TAB[13] % 64'd10),
		4'(LIM_TAB[14] % 64'd10), 4'(LIM_TAB[15] % 64'd10)
	};

	typedef struct packed {
		logic [1:0] width;
		logic       sgn;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] mag;
		logic               neg;
		cfg_t               cfg;
		logic [COUNT_W-1:0] count;
	} raw_t;

	function automatic logic [VALUE_W-1:0] width_mask(input logic [1:0] width);
		logic [VALUE_W-1:0] m;
		case (width)
			2'd0: m = 64'hFF;
			2'd1: m = 64'hFFFF;
			2'd2: m = 64'hFFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/dtti_regs.sv =====
// dtti_regs: APB-style configuration registers (target width, signedness).
// Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtti_pkg::PADDR_W-1:0] paddr,
	input  logic [dtti_pkg::PDATA_W-1:0] pwdata,
	output logic [dtti_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output dtti_pkg::cfg_t               cfg
);

	logic       wr_en;
	logic [1:0] width_q;
	logic       sgn_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 2'd2;
			sgn_q   <= 1'b1;
		end else if (wr_en) begin
			if (paddr[2] == dtti_pkg::REG_VALUE_WIDTH) begin
				width_q <= pwdata[1:0];
			end else begin
				sgn_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == dtti_pkg::REG_VALUE_WIDTH) begin
			prdata = {{(dtti_pkg::PDATA_W-2){1'b0}}, width_q};
		end else begin
			prdata = {{(dtti_pkg::PDATA_W-1){1'b0}}, sgn_q};
		end
	end

	assign cfg.width = width_q;
	assign cfg.sgn   = sgn_q;

endmodule

// ===== hw/rtl/dtti_parse.sv =====
// dtti_parse: input register, per-character parse state update and raw result register.
// Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  dtti_pkg::cfg_t cfg,
	input  logic [7:0]     char_code,
	input  logic           last_char,
	input  logic           char_valid,
	output logic           char_stall,
	output logic           raw_vld,
	output dtti_pkg::raw_t raw,
	input  logic           fmt_rdy
);

	logic                       s1_vld;
	logic [7:0]                 char_s1;
	logic                       last_s1;
	logic                       s2_vld;
	dtti_pkg::raw_t             raw_s2;
	logic                       s2_free;
	logic                       adv;

	logic [2:0]                     phase_q, phase_n;
	logic [dtti_pkg::VALUE_W-1:0]   mag_q, mag_n, pre;
	logic                           neg_q, neg_n;
	logic                           zero_q, zero_n;
	logic [dtti_pkg::POS_W-1:0]     pos_q, pos_n;
	logic                           consume, do_digit;
	logic                           is_space, is_minus, is_digit, ovf;
	logic [3:0]                     dig, rem;
	logic [3:0]                     lim_idx;
	logic [1:0]                     status_n;

	assign s2_free    = !s2_vld || fmt_rdy;
	assign adv        = s1_vld && s2_free;
	assign char_stall = s1_vld && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (!char_stall) begin
			s1_vld <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	assign is_space = (char_s1 == dtti_pkg::CH_SPACE) || (char_s1 == dtti_pkg::CH_TAB) ||
		(char_s1 == dtti_pkg::CH_CR) || (char_s1 == dtti_pkg::CH_LF);
	assign is_minus = (char_s1 == dtti_pkg::CH_MINUS);
	assign is_digit = (char_s1 >= dtti_pkg::CH_ZERO) && (char_s1 <= dtti_pkg::CH_NINE);
	assign dig      = 4'(char_s1 - dtti_pkg::CH_ZERO);

	assign lim_idx = {cfg.sgn, cfg.sgn & neg_q, cfg.width};
	assign pre     = dtti_pkg::PRE_TAB[lim_idx];
	assign rem     = dtti_pkg::REM_TAB[lim_idx];
	assign ovf     = (mag_q > pre) || ((mag_q == pre) && (dig > rem));

	always_comb begin
		phase_n  = phase_q;
		mag_n    = mag_q;
		neg_n    = neg_q;
		zero_n   = zero_q;
		consume  = 1'b0;
		do_digit = 1'b0;
		case (phase_q)
			dtti_pkg::PH_WS: begin
				if (is_space) begin
					consume = 1'b1;
				end else if (is_minus) begin
					if (!cfg.sgn) begin
						phase_n = dtti_pkg::PH_OVERFLOW;
					end else begin
						neg_n   = 1'b1;
						consume = 1'b1;
						phase_n = dtti_pkg::PH_WS_SIGN;
					end
				end else begin
					do_digit = 1'b1;
				end
			end
			dtti_pkg::PH_WS_SIGN: begin
				if (is_space) begin
					consume = 1'b1;
				end else begin
					do_digit = 1'b1;
				end
			end
			dtti_pkg::PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
			end
		endcase
		if (do_digit) begin
			if (!is_digit) begin
				phase_n = dtti_pkg::PH_ENDED;
			end else if (ovf) begin
				phase_n = dtti_pkg::PH_OVERFLOW;
			end else begin
				if ((mag_q == '0) && (dig == 4'd0)) begin
					zero_n = 1'b1;
				end
				mag_n   = (mag_q << 3) + (mag_q << 1) + dtti_pkg::VALUE_W'(dig);
				consume = 1'b1;
				phase_n = dtti_pkg::PH_DIGITS;
			end
		end
		pos_n = pos_q;
		if (consume && (pos_q < dtti_pkg::POS_MAX)) begin
			pos_n = pos_q + 1'b1;
		end
	end

	always_comb begin
		if (phase_n == dtti_pkg::PH_OVERFLOW) begin
			status_n = dtti_pkg::ST_OVERFLOW;
		end else if ((phase_n == dtti_pkg::PH_WS) || (phase_n == dtti_pkg::PH_WS_SIGN)) begin
			status_n = dtti_pkg::ST_PARSE_ERR;
		end else if ((mag_n == '0) && !zero_n) begin
			status_n = dtti_pkg::ST_PARSE_ERR;
		end else begin
			status_n = dtti_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtti_pkg::PH_WS;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			zero_q  <= 1'b0;
			pos_q   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= dtti_pkg::PH_WS;
				mag_q   <= '0;
				neg_q   <= 1'b0;
				zero_q  <= 1'b0;
				pos_q   <= '0;
			end else begin
				phase_q <= phase_n;
				mag_q   <= mag_n;
				neg_q   <= neg_n;
				zero_q  <= zero_n;
				pos_q   <= pos_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld <= 1'b0;
		end else if (s2_free) begin
			s2_vld <= adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1 && s2_free) begin
			raw_s2.status <= status_n;
			raw_s2.mag    <= mag_n;
			raw_s2.neg    <= neg_n;
			raw_s2.cfg    <= cfg;
			raw_s2.count  <= dtti_pkg::COUNT_W'(pos_n);
		end
	end

	assign raw_vld = s2_vld;
	assign raw     = raw_s2;

	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (phase_q == dtti_pkg::PH_WS && mag_q == '0 && pos_q == '0 && !neg_q))
		else $error("field state not cleared after last character");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= dtti_pkg::POS_MAX)
		else $error("character position beyond saturation limit");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1 && phase_q == dtti_pkg::PH_OVERFLOW) |=>
		(phase_q == dtti_pkg::PH_OVERFLOW))
		else $error("overflow phase left before end of field");

	a_no_result_midfield: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_free && !(adv && last_s1)) |=> !s2_vld)
		else $error("raw result without a last character");

endmodule

// ===== hw/rtl/dtti_fmt.sv =====
// dtti_fmt: sign application, width masking and the output register of the result channel.
// Depends on dtti_pkg.
`timescale 1ns / 1ps

module dtti_fmt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         raw_vld,
	input  dtti_pkg::raw_t               raw,
	output logic                         fmt_rdy,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [1:0]                   status,
	output logic [dtti_pkg::VALUE_W-1:0] value_bits,
	output logic [dtti_pkg::COUNT_W-1:0] consumed_count
);

	logic                         out_vld_q;
	logic [1:0]                   status_q;
	logic [dtti_pkg::VALUE_W-1:0] value_q, val;
	logic [dtti_pkg::COUNT_W-1:0] count_q, cnt;

	assign fmt_rdy = !out_vld_q || !result_stall;

	always_comb begin
		val = raw.neg ? (~raw.mag + 1'b1) : raw.mag;
		if (!raw.cfg.sgn) begin
			val = val & dtti_pkg::width_mask(raw.cfg.width);
		end
		cnt = raw.count;
		if (raw.status != dtti_pkg::ST_OK) begin
			val = '0;
			cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fmt_rdy) begin
			out_vld_q <= raw_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fmt_rdy && raw_vld) begin
			status_q <= raw.status;
			value_q  <= val;
			count_q  <= cnt;
		end
	end

	assign result_valid   = out_vld_q;
	assign status         = status_q;
	assign value_bits     = value_q;
	assign consumed_count = count_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && status_q != dtti_pkg::ST_OK) |-> (value_q == '0 && count_q == '0))
		else $error("error result carries nonzero value or count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (status_q == dtti_pkg::ST_OK || status_q == dtti_pkg::ST_PARSE_ERR ||
			status_q == dtti_pkg::ST_OVERFLOW))
		else $error("undefined status code on result");

endmodule

// ===== hw/rtl/decimal_text_to_integer.sv =====
// decimal_text_to_integer: streaming decimal text to integer converter, top level.
// Depends on dtti_pkg, dtti_regs, dtti_parse, dtti_fmt.
//
// Usage: characters enter on the char channel (char_code, last_char, char_valid,
// char_stall), one item per byte; last_char marks the final byte of a field.
// Exactly one result per field leaves on the result channel (status, value_bits,
// consumed_count, result_valid, result_stall), for the item that carries last_char.
// A result passes through the input register, the parse state update into the raw
// result register, and the output register. Throughput: one item per cycle while
// char_stall is low; the per-character state loop (multiply by ten, add digit,
// compare against the limit table) is combinational. When result_stall holds, the
// output register keeps its item, the raw result register and then the input
// register fill, and char_stall rises; nothing is lost. The user must write
// configuration (value_width, signed_mode) over the APB port only while idle; the
// block does not enforce this. Reset: all channels empty, parse state at leading
// whitespace, value_width = 32 bits, signed_mode = 1. No clearing pass is needed.
`timescale 1ns / 1ps

module decimal_text_to_integer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtti_pkg::PADDR_W-1:0] paddr,
	input  logic [dtti_pkg::PDATA_W-1:0] pwdata,
	output logic [dtti_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic [7:0]                   char_code,
	input  logic                         last_char,
	input  logic                         char_valid,
	output logic                         char_stall,
	output logic [1:0]                   status,
	output logic [dtti_pkg::VALUE_W-1:0] value_bits,
	output logic [dtti_pkg::COUNT_W-1:0] consumed_count,
	output logic                         result_valid,
	input  logic                         result_stall
);

	dtti_pkg::cfg_t cfg;
	dtti_pkg::raw_t raw;
	logic           raw_vld;
	logic           fmt_rdy;

	dtti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtti_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.raw_vld    (raw_vld),
		.raw        (raw),
		.fmt_rdy    (fmt_rdy)
	);

	dtti_fmt u_fmt (
		.clk            (clk),
		.arst_n         (arst_n),
		.raw_vld        (raw_vld),
		.raw            (raw),
		.fmt_rdy        (fmt_rdy),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.value_bits     (value_bits),
		.consumed_count (consumed_count)
	);

endmodule
